// ===== src/ainl_pkg.sv =====
// Package for the archive index name lookup unit.
// Holds the item types, command and status codes and the filename folding function.
// Depends on nothing; every other file imports it.
package ainl_pkg;

    // Command codes of an input item.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Status codes of a result item.
    localparam logic [2:0] STAT_LOADED   = 3'd0;
    localparam logic [2:0] STAT_REPLACED = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_HIT      = 3'd3;
    localparam logic [2:0] STAT_MISS     = 3'd4;

    // Archive header bytes and bytes per index entry, for the offset adjustment.
    localparam int unsigned HDR_BYTES   = 6;
    localparam int unsigned ENTRY_BYTES = 12;
    localparam int unsigned ADJ_W       = 20;

    typedef struct packed {
        logic        command;
        logic [31:0] entry_id;
        logic [31:0] entry_offset;
        logic [31:0] entry_size;
        logic [31:0] name_word0;
        logic [31:0] name_word1;
        logic [31:0] name_word2;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] name_id;
        logic [31:0] found_offset;
        logic [31:0] found_size;
    } t_out_item;

    // One stored index entry.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] offset;
        logic [31:0] size;
    } t_entry;

    // Response of the hash unit.
    typedef struct packed {
        logic        done;
        logic [31:0] id;
    } t_hash_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Upper-cases letters and zeroes every byte from the first zero byte on.
    // Bit 32 of the result reports whether the word held a zero byte.
    function automatic logic [32:0] fold_word(input logic [31:0] word);
        logic [31:0] folded;
        logic        ended;
        logic [7:0]  c;
        folded = '0;
        ended  = 1'b0;
        for (int j = 0; j < 4; j++) begin
            c = word[8*j +: 8];
            if (c == 8'h00) begin
                ended = 1'b1;
            end
            if (ended) begin
                c = 8'h00;
            end else if (c inside {[8'h61:8'h7A]}) begin
                c = c - 8'h20;
            end
            folded[8*j +: 8] = c;
        end
        return {ended, folded};
    endfunction

endpackage

// ===== src/ainl_in_if.sv =====
// Input channel of the archive index name lookup unit: valid, ready and one item.
// Depends on ainl_pkg for the item type.
interface ainl_in_if import ainl_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ainl_out_if.sv =====
// Result channel of the archive index name lookup unit: valid, ready and one item.
// Depends on ainl_pkg for the item type.
interface ainl_out_if import ainl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ainl_name_hash.sv =====
// Iterative filename hash: one 32-bit name word folded, rotated and added per cycle.
// Depends on ainl_pkg for fold_word and t_hash_rsp.
module ainl_name_hash import ainl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0][31:0] i_words,
    output t_hash_rsp        o_rsp
);

    logic             r_busy;
    logic [1:0]       r_k;
    logic [31:0]      r_id;
    logic [2:0][31:0] r_words;
    logic             r_done;

    logic [32:0]      w_fold;
    logic             w_stop_now;
    logic             w_last;

    // Fold the current word; a zero first byte ends the name before this word.
    always_comb begin
        w_fold     = fold_word(r_words[r_k]);
        w_stop_now = (w_fold[7:0] == 8'h00);
        w_last     = w_fold[32] || (r_k == 2'd2);
    end

    // Control: busy flag, word counter and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (w_stop_now || w_last);
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (w_stop_now || w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
        end
    end

    // Datapath: the running id and the captured name words.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_words <= i_words;
            r_id    <= '0;
        end else if (r_busy && !w_stop_now) begin
            r_id <= {r_id[30:0], r_id[31]} + w_fold[31:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.id   = r_id;

endmodule

// ===== src/archive_index_name_lookup_unit.sv =====
// Top level of the archive index name lookup unit: sequencer, entry memory, result register.
// Depends on ainl_pkg, ainl_in_if, ainl_out_if and ainl_name_hash.
//
//  Channel  | Dir | Handshake        | Carries
//  ---------+-----+------------------+-----------------------------------------
//  i_item   | in  | valid / ready    | command, entry fields, three name words
//  o_res    | out | valid / ready    | status, name id, found offset and size
//  APB      | in  | psel / penable   | entry_count at byte address 0
//
// A load scans the stored entries for its id, and a lookup hashes the name first and then scans:
// the entry memory has one read port and is scanned linearly, one entry per cycle.
// One item is worked on at a time; a new item is taken while the result waits.
// Reset is synchronous; the memory needs no clearing pass, as only the first
// stored_count entries are ever read. A stalled result holds the sequencer in its
// final state until the result register is free.
module archive_index_name_lookup_unit import ainl_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ainl_in_if.sink     i_item,
    ainl_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = $clog2((TABLE_DEPTH > 1) ? TABLE_DEPTH : 2);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // Entry memory, written in the final state and read during the scan.
    t_entry      r_mem [TABLE_DEPTH];
    t_entry      r_rdata;

    t_state      r_state;
    t_state      n_state;

    logic        r_cmd;
    logic [31:0] r_key;
    logic [31:0] r_off;
    logic [31:0] r_size;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_issue;
    logic          r_pend;
    logic [AW-1:0] r_pend_slot;
    logic          r_hit;
    logic [AW-1:0] r_hit_slot;
    logic [31:0]   r_hit_off;
    logic [31:0]   r_hit_size;

    logic [15:0]      r_entry_count;
    logic [ADJ_W-1:0] r_adjust;
    logic [ADJ_W-1:0] n_adjust;

    t_out_item   r_out;
    t_out_item   n_out;
    logic        r_out_valid;

    t_hash_rsp   w_hash;
    logic        w_accept;
    logic        w_cfg_wr;
    logic        w_rd_en;
    logic        w_hit_now;
    logic        w_scan_miss;
    logic        w_out_free;
    logic        w_finish;
    logic        w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic        w_new_entry;
    logic        w_full;

    // Configuration port: one register, the adjustment is kept precomputed.
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign n_adjust = (ADJ_W'(pwdata[15:0]) << 3) + (ADJ_W'(pwdata[15:0]) << 2)
                    + ADJ_W'(HDR_BYTES);
    assign prdata   = (paddr[2] == 1'b0) ? {16'h0000, r_entry_count} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_adjust      <= ADJ_W'(HDR_BYTES);
        end else if (w_cfg_wr && (paddr[2] == 1'b0)) begin
            r_entry_count <= pwdata[15:0];
            r_adjust      <= n_adjust;
        end
    end

    // Filename hash unit.
    ainl_name_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (i_item.payload.command == CMD_LOOKUP)),
        .i_words ({i_item.payload.name_word2, i_item.payload.name_word1,
                   i_item.payload.name_word0}),
        .o_rsp   (w_hash)
    );

    // Handshake and scan control.
    always_comb begin
        i_item.ready = (r_state == ST_IDLE);
        w_accept     = i_item.valid && (r_state == ST_IDLE);
        w_hit_now    = (r_state == ST_SCAN) && r_pend && (r_rdata.id == r_key);
        w_scan_miss  = (r_state == ST_SCAN) && !r_pend && (r_issue == r_count);
        w_rd_en      = (r_state == ST_SCAN) && (r_issue < r_count) && !w_hit_now;
        w_out_free   = !r_out_valid || o_res.ready;
        w_finish     = (r_state == ST_DONE) && w_out_free;
        w_full       = (r_count >= CW'(TABLE_DEPTH));
        w_new_entry  = (r_cmd == CMD_LOAD) && !r_hit && !w_full;
        w_wr_en      = w_finish && (r_cmd == CMD_LOAD) && (r_hit || !w_full);
        w_wr_addr    = r_hit ? r_hit_slot : r_count[AW-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_item.payload.command == CMD_LOOKUP) ? ST_HASH : ST_SCAN;
                end
            end
            ST_HASH: begin
                if (w_hash.done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit_now || w_scan_miss) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result item built in the final state.
    always_comb begin
        n_out = '0;
        if (r_cmd == CMD_LOAD) begin
            if (r_hit) begin
                n_out.status = STAT_REPLACED;
            end else if (w_full) begin
                n_out.status = STAT_FULL;
            end else begin
                n_out.status = STAT_LOADED;
            end
        end else begin
            n_out.name_id = r_key;
            if (r_hit) begin
                n_out.status       = STAT_HIT;
                n_out.found_offset = r_hit_off + 32'(r_adjust);
                n_out.found_size   = r_hit_size;
            end else begin
                n_out.status = STAT_MISS;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_rd_en;
            if (w_accept) begin
                r_issue <= '0;
                r_hit   <= 1'b0;
            end else if (w_rd_en) begin
                r_issue <= r_issue + CW'(1);
            end
            if (w_hit_now) begin
                r_hit <= 1'b1;
            end
            if (w_finish && w_new_entry) begin
                r_count <= r_count + CW'(1);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the item in work and the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_item.payload.command;
            r_key  <= i_item.payload.entry_id;
            r_off  <= i_item.payload.entry_offset;
            r_size <= i_item.payload.entry_size;
        end else if ((r_state == ST_HASH) && w_hash.done) begin
            r_key <= w_hash.id;
        end
        if (w_rd_en) begin
            r_pend_slot <= r_issue[AW-1:0];
        end
        if (w_hit_now) begin
            r_hit_slot <= r_pend_slot;
            r_hit_off  <= r_rdata.offset;
            r_hit_size <= r_rdata.size;
        end
        if (w_finish) begin
            r_out <= n_out;
        end
    end

    // Entry memory. Reads happen only in the scan and writes only in the final
    // state, so one entry is never read and written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= '{id: r_key, offset: r_off, size: r_size};
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_issue[AW-1:0]];
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

// ===== src/ainl_checker.sv =====
// Port-level checker for the archive index name lookup unit, with its bind statement.
// Depends on ainl_pkg and on the top level archive_index_name_lookup_unit.
module ainl_checker import ainl_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    logic [1:0] r_outstanding;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Items accepted whose result has not yet been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_outstanding <= r_outstanding + 2'd1;
        end else if (w_out_acc && !w_in_acc) begin
            r_outstanding <= r_outstanding - 2'd1;
        end
    end

    // A waiting result keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result item changed while stalled");

    // At most one item in work and one result waiting.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> r_outstanding <= 2'd2)
        else $error("too many items outstanding");

    // No result item without an accepted item behind it.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outstanding != 2'd0)
        else $error("result item without an accepted item");

    // Load results and misses carry no offset or size.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.status == STAT_LOADED
            || i_out_item.status == STAT_REPLACED || i_out_item.status == STAT_FULL
            || i_out_item.status == STAT_MISS)
        |-> i_out_item.found_offset == 32'h0 && i_out_item.found_size == 32'h0)
        else $error("offset or size set on a result that is not a hit");

endmodule

bind archive_index_name_lookup_unit ainl_checker u_ainl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_item  (o_res.payload)
);
